// File: src/nfss_pkg.sv
// Shared types and codes of the nearest free subset sampler.
// No dependencies; imported by the engine and the top level.

package nfss_pkg;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_NONE  = 2'd3;

   localparam logic REG_POOL_SIZE = 1'b0;

   localparam logic [10:0] POOL_SIZE_RESET = 11'd1024;

   typedef struct packed {
      logic [1:0] action;
      logic [9:0] draw_key;
      logic       coin;
   } req_type;

   typedef struct packed {
      logic [9:0] chosen_index;
      logic [1:0] status;
      logic       last;
   } res_type;

endpackage

// File: src/nfss_engine.sv
// Availability bitmap in a word-wide synchronous memory plus the sequencer
// that clears it, searches nearest free indices and reads taken indices.
// Depends on nfss_pkg.

module nfss_engine import nfss_pkg::*; #(
   parameter int MAX_POOL = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [10:0] pool_size,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req,
   output logic        res_valid,
   input  logic        res_ready,
   output res_type     res
);

   localparam int WORDS       = (MAX_POOL + 31) / 32;
   localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW          = AW + 5;
   localparam int LW          = $clog2(MAX_POOL + 1);
   localparam int RESET_LIMIT = (MAX_POOL < 1024) ? MAX_POOL : 1024;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_KEY, S_LO, S_HI, S_PICK, S_FIND, S_LAST, S_RESP
   } state_type;

   function automatic logic [4:0] msb32(logic [31:0] v);
      logic [4:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

   function automatic logic [4:0] lsb32(logic [31:0] v);
      logic [4:0] r;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

   function automatic logic [31:0] low_mask(logic [4:0] off);
      return (32'd1 << off) - 32'd1;
   endfunction

   function automatic logic [31:0] above_mask(logic [4:0] off);
      return ~((32'd2 << off) - 32'd1);
   endfunction

   function automatic logic [31:0] limit_mask(logic [AW-1:0] w, logic [XW:0] lim);
      logic [AW:0] lw;
      logic [AW:0] wx;
      lw = lim[XW:5];
      wx = {1'b0, w};
      if (wx < lw) return '1;
      else if (wx == lw) return low_mask(lim[4:0]);
      else return '0;
   endfunction

   logic [31:0] mem [WORDS];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [31:0] mem_wdata;

   state_type   state_ff, state_in;
   logic [AW-1:0] word_ff, word_in;
   logic [LW-1:0] plim_ff, plim_in;
   logic [LW-1:0] free_count_ff, free_count_in;
   logic [LW-1:0] cursor_ff, cursor_in;
   logic        pend_ff, pend_in;
   logic        first_ff, first_in;
   logic        hi_scan_ff, hi_scan_in;
   logic [XW-1:0] key_ff, key_in;
   logic        coin_ff, coin_in;
   logic        lo_found_ff, lo_found_in;
   logic        hi_found_ff, hi_found_in;
   logic [XW-1:0] lo_idx_ff, lo_idx_in;
   logic [XW-1:0] hi_idx_ff, hi_idx_in;
   logic [31:0] lo_data_ff, lo_data_in;
   logic [31:0] hi_data_ff, hi_data_in;
   res_type     res_ff, res_in;

   logic [XW:0]   plim_x;
   logic [XW:0]   plim_m1;
   logic [AW-1:0] last_word;
   logic [XW-1:0] cur_x;
   logic [XW-1:0] new_key;
   logic [4:0]    koff;
   logic [AW-1:0] key_word;
   logic [31:0]   lo_c;
   logic [31:0]   hi_c;
   logic [31:0]   lim_mask;
   logic [31:0]   taken;
   logic [4:0]    tb;
   logic [XW-1:0] taken_idx;
   logic [XW:0]   taken_next;
   logic [XW-1:0] dl;
   logic [XW-1:0] dh;
   logic          pick_hi;
   logic [XW-1:0] sel_idx;
   logic [31:0]   sel_data;
   logic [31:0]   ps_w;
   logic [31:0]   ps_eff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   assign plim_x    = (XW+1)'(plim_ff);
   assign plim_m1   = plim_x - 1'b1;
   assign last_word = plim_m1[XW-1:5];
   assign cur_x     = XW'(cursor_ff);
   assign new_key   = XW'(req.draw_key);
   assign koff      = key_ff[4:0];
   assign key_word  = key_ff[XW-1:5];
   assign lo_c      = rdata_ff & low_mask(koff);
   assign hi_c      = rdata_ff & above_mask(koff);
   assign lim_mask  = limit_mask(word_ff, plim_x);
   assign taken     = ~rdata_ff & lim_mask & (first_ff ? ~low_mask(cur_x[4:0]) : '1);
   assign tb        = lsb32(taken);
   assign taken_idx = {word_ff, tb};
   assign taken_next = {1'b0, taken_idx} + 1'b1;
   assign dl        = key_ff - lo_idx_ff;
   assign dh        = hi_idx_ff - key_ff;
   assign pick_hi   = hi_found_ff && (!lo_found_ff || (dh < dl) || ((dh == dl) && coin_ff));
   assign sel_idx   = pick_hi ? hi_idx_ff : lo_idx_ff;
   assign sel_data  = pick_hi ? hi_data_ff : lo_data_ff;
   assign ps_w      = {21'd0, pool_size};
   assign ps_eff    = (ps_w == 32'd0) ? 32'd1 :
                      (ps_w > 32'(MAX_POOL)) ? 32'(MAX_POOL) : ps_w;

   assign res = res_ff;

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      plim_in       = plim_ff;
      free_count_in = free_count_ff;
      cursor_in     = cursor_ff;
      pend_in       = pend_ff;
      first_in      = first_ff;
      hi_scan_in    = hi_scan_ff;
      key_in        = key_ff;
      coin_in       = coin_ff;
      lo_found_in   = lo_found_ff;
      hi_found_in   = hi_found_ff;
      lo_idx_in     = lo_idx_ff;
      hi_idx_in     = hi_idx_ff;
      lo_data_in    = lo_data_ff;
      hi_data_in    = hi_data_ff;
      res_in        = res_ff;
      mem_raddr     = word_ff;
      mem_we        = 1'b0;
      mem_waddr     = word_ff;
      mem_wdata     = rdata_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = lim_mask;
            word_in   = word_ff + 1'b1;
            if (word_ff == AW'(WORDS - 1)) begin
               word_in       = word_ff;
               free_count_in = plim_ff;
               cursor_in     = '0;
               pend_in       = 1'b0;
               state_in      = pend_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in   = '0;
               state_in = S_RESP;
               case (req.action)
                  ACT_CLEAR: begin
                     plim_in  = LW'(ps_eff);
                     word_in  = '0;
                     pend_in  = 1'b1;
                     state_in = S_CLR;
                  end
                  ACT_DRAW: begin
                     if (free_count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else if ({22'd0, req.draw_key} >= 32'(plim_ff)) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        key_in      = new_key;
                        coin_in     = req.coin;
                        word_in     = new_key[XW-1:5];
                        mem_raddr   = new_key[XW-1:5];
                        lo_found_in = 1'b0;
                        hi_found_in = 1'b0;
                        state_in    = S_KEY;
                     end
                  end
                  ACT_READ: begin
                     if (cursor_ff >= plim_ff) begin
                        res_in.status = STAT_NONE;
                        res_in.last   = 1'b1;
                     end else begin
                        word_in   = cur_x[XW-1:5];
                        mem_raddr = cur_x[XW-1:5];
                        first_in  = 1'b1;
                        state_in  = S_FIND;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_KEY: begin
            if (rdata_ff[koff]) begin
               mem_we              = 1'b1;
               mem_wdata           = rdata_ff & ~(32'd1 << koff);
               free_count_in       = free_count_ff - 1'b1;
               res_in.chosen_index = 10'(key_ff);
               state_in            = S_RESP;
            end else begin
               lo_found_in = (lo_c != '0);
               lo_idx_in   = {word_ff, msb32(lo_c)};
               lo_data_in  = rdata_ff;
               hi_found_in = (hi_c != '0);
               hi_idx_in   = {word_ff, lsb32(hi_c)};
               hi_data_in  = rdata_ff;
               hi_scan_in  = (hi_c == '0) && (word_ff != last_word);
               if ((lo_c == '0) && (word_ff != '0)) begin
                  word_in   = word_ff - 1'b1;
                  mem_raddr = word_ff - 1'b1;
                  state_in  = S_LO;
               end else if ((hi_c == '0) && (word_ff != last_word)) begin
                  word_in   = word_ff + 1'b1;
                  mem_raddr = word_ff + 1'b1;
                  state_in  = S_HI;
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_LO: begin
            if ((rdata_ff != '0) || (word_ff == '0)) begin
               lo_found_in = (rdata_ff != '0);
               lo_idx_in   = {word_ff, msb32(rdata_ff)};
               lo_data_in  = rdata_ff;
               if (hi_scan_ff) begin
                  word_in   = key_word + 1'b1;
                  mem_raddr = key_word + 1'b1;
                  state_in  = S_HI;
               end else begin
                  state_in = S_PICK;
               end
            end else begin
               word_in   = word_ff - 1'b1;
               mem_raddr = word_ff - 1'b1;
            end
         end
         S_HI: begin
            if ((rdata_ff != '0) || (word_ff == last_word)) begin
               hi_found_in = (rdata_ff != '0);
               hi_idx_in   = {word_ff, lsb32(rdata_ff)};
               hi_data_in  = rdata_ff;
               state_in    = S_PICK;
            end else begin
               word_in   = word_ff + 1'b1;
               mem_raddr = word_ff + 1'b1;
            end
         end
         S_PICK: begin
            mem_we              = 1'b1;
            mem_waddr           = sel_idx[XW-1:5];
            mem_wdata           = sel_data & ~(32'd1 << sel_idx[4:0]);
            free_count_in       = free_count_ff - 1'b1;
            res_in.chosen_index = 10'(sel_idx);
            state_in            = S_RESP;
         end
         S_FIND: begin
            first_in = 1'b0;
            if (taken != '0) begin
               res_in.chosen_index = 10'(taken_idx);
               cursor_in           = LW'(taken_next);
               if ((taken & above_mask(tb)) != '0) begin
                  res_in.last = 1'b0;
                  state_in    = S_RESP;
               end else if (word_ff == last_word) begin
                  res_in.last = 1'b1;
                  state_in    = S_RESP;
               end else begin
                  word_in   = word_ff + 1'b1;
                  mem_raddr = word_ff + 1'b1;
                  state_in  = S_LAST;
               end
            end else if (word_ff == last_word) begin
               res_in.status = STAT_NONE;
               res_in.last   = 1'b1;
               state_in      = S_RESP;
            end else begin
               word_in   = word_ff + 1'b1;
               mem_raddr = word_ff + 1'b1;
            end
         end
         S_LAST: begin
            if (taken != '0) begin
               res_in.last = 1'b0;
               state_in    = S_RESP;
            end else if (word_ff == last_word) begin
               res_in.last = 1'b1;
               state_in    = S_RESP;
            end else begin
               word_in   = word_ff + 1'b1;
               mem_raddr = word_ff + 1'b1;
            end
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         word_ff       <= '0;
         plim_ff       <= LW'(RESET_LIMIT);
         free_count_ff <= LW'(RESET_LIMIT);
         cursor_ff     <= '0;
         pend_ff       <= 1'b0;
         first_ff      <= 1'b0;
         hi_scan_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         plim_ff       <= plim_in;
         free_count_ff <= free_count_in;
         cursor_ff     <= cursor_in;
         pend_ff       <= pend_in;
         first_ff      <= first_in;
         hi_scan_ff    <= hi_scan_in;
      end
      key_ff      <= key_in;
      coin_ff     <= coin_in;
      lo_found_ff <= lo_found_in;
      hi_found_ff <= hi_found_in;
      lo_idx_ff   <= lo_idx_in;
      hi_idx_ff   <= hi_idx_in;
      lo_data_ff  <= lo_data_in;
      hi_data_ff  <= hi_data_in;
      res_ff      <= res_in;
   end

endmodule

// File: src/nearest_free_subset_sampler.sv
// Top level of the nearest free subset sampler: register port, request and
// response streams, output register. Depends on nfss_pkg and nfss_engine.
//
//   channel   direction  handshake                 payload
//   req_*     in         tvalid/tready             tdata: key, coin; tuser: action
//   rsp_*     out        tvalid/tready             tdata: index, status; tlast
//   csr_*     in         psel/penable/pwrite       pool_size at byte address 0
//
// Bitmap words of 32 indices sit in one memory, one word read per cycle.
// Clear writes every bitmap word in turn. Draw reads the key's word and, when the
// key is taken, scans words down and up for the nearest free index before picking;
// a rejected draw goes straight to the response. Read scans words from the cursor.
// After reset a clearing pass over every bitmap word runs before requests are taken.
// A finished response waits in the output register while the next request is taken.

module nearest_free_subset_sampler import nfss_pkg::*; #(
   parameter int MAX_POOL = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] draw_key, [10] coin, [15:11] zero
   input  logic [1:0]  req_tuser,    // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [9:0] chosen_index, [11:10] status, [15:12] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [10:0] pool_size_ff;
   logic        rsp_valid_ff;
   res_type     rsp_ff;
   req_type     eng_req;
   res_type     eng_res;
   logic        eng_res_valid;
   logic        eng_res_ready;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_POOL_SIZE);
   assign csr_prdata = (csr_paddr[2] == REG_POOL_SIZE) ? {21'd0, pool_size_ff} : 32'd0;

   assign eng_req.action   = req_tuser;
   assign eng_req.draw_key = req_tdata[9:0];
   assign eng_req.coin     = req_tdata[10];

   assign eng_res_ready = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.status, rsp_ff.chosen_index};
   assign rsp_tlast  = rsp_ff.last;

   nfss_engine #(
      .MAX_POOL (MAX_POOL)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pool_size (pool_size_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (eng_req),
      .res_valid (eng_res_valid),
      .res_ready (eng_res_ready),
      .res       (eng_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= POOL_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) pool_size_ff <= csr_pwdata[10:0];
         if (eng_res_ready) rsp_valid_ff <= eng_res_valid;
      end
      if (eng_res_ready && eng_res_valid) rsp_ff <= eng_res;
   end

endmodule

// File: tb/tb_nearest_free_subset_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_free_subset_sampler: directed and random
// clear/draw/read requests, checked against a bitmap pool model in a scoreboard.
// Depends on nfss_pkg and the sampler RTL.

module tb_nearest_free_subset_sampler;
   import nfss_pkg::*;

   localparam int MAX_POOL = 1024;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int TARGET_REQUESTS = 1900;

   class sampler_scoreboard;
      logic [MAX_POOL-1:0] free_map;
      int unsigned free_count;
      int unsigned read_cursor;
      int unsigned pool_limit;
      logic [10:0] pool_size;
      res_type expected_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned status_seen[4];

      function new();
         pool_size = POOL_SIZE_RESET;
         errors = 0;
         checked = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
         clear_pool();
      endfunction

      function void clear_pool();
         int unsigned i;
         pool_limit = (pool_size == 0) ? 1 : (pool_size > MAX_POOL) ? MAX_POOL : pool_size;
         for (i = 0; i < MAX_POOL; i++) free_map[i] = (i < pool_limit);
         free_count = pool_limit;
         read_cursor = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type r);
         int unsigned key, pick, lo, hi, i;
         bit has_lo, has_hi, found;
         res_type e;
         e = '0;
         key = r.draw_key;
         case (r.action)
            ACT_CLEAR: clear_pool();
            ACT_DRAW: begin
               if (free_count == 0) begin
                  e.status = STAT_EMPTY;
               end else if (key >= pool_limit) begin
                  e.status = STAT_RANGE;
               end else begin
                  pick = key;
                  if (!free_map[key]) begin
                     has_lo = 0;
                     has_hi = 0;
                     lo = 0;
                     hi = 0;
                     for (i = key; i > 0; i--) begin
                        if (free_map[i-1]) begin
                           lo = i - 1;
                           has_lo = 1;
                           break;
                        end
                     end
                     for (i = key + 1; i < pool_limit; i++) begin
                        if (free_map[i]) begin
                           hi = i;
                           has_hi = 1;
                           break;
                        end
                     end
                     if (!has_hi) pick = lo;
                     else if (!has_lo) pick = hi;
                     else if (key - lo < hi - key) pick = lo;
                     else if (hi - key < key - lo) pick = hi;
                     else pick = r.coin ? hi : lo;
                  end
                  free_map[pick] = 1'b0;
                  free_count--;
                  e.chosen_index = 10'(pick);
               end
            end
            ACT_READ: begin
               found = 0;
               for (i = read_cursor; i < pool_limit; i++) begin
                  if (!free_map[i]) begin
                     found = 1;
                     break;
                  end
               end
               e.last = 1'b1;
               if (!found) begin
                  e.status = STAT_NONE;
               end else begin
                  e.chosen_index = 10'(i);
                  read_cursor = i + 1;
                  for (i = read_cursor; i < pool_limit; i++) begin
                     if (!free_map[i]) begin
                        e.last = 1'b0;
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         status_seen[e.status]++;
         expected_q.push_back(e);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) $display("%0t ns: mismatch: %s", $time, msg);
      endtask

      task check_result(logic [9:0] idx, logic [1:0] st, logic lst);
         res_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result index %0d status %0d last %0b",
                                      idx, st, lst));
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (idx !== e.chosen_index || st !== e.status || lst !== e.last)
            report_mismatch($sformatf("got index %0d status %0d last %0b, want %0d %0d %0b",
                                      idx, st, lst, e.chosen_index, e.status, e.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [9:0] draw_key, [10] coin, [15:11] zero
   logic [1:0]  req_tuser = '0;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [9:0] chosen_index, [11:10] status, [15:12] zero
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sampler_scoreboard sb;
   bit          quiet_mode = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned rsp_hold = 0;

   nearest_free_subset_sampler #(.MAX_POOL(MAX_POOL)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[9:0], rsp_tdata[11:10], rsp_tlast);
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         rsp_hold = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [9:0] key, input logic coin);
      req_type item;
      int unsigned gap;
      item.action = act;
      item.draw_key = key;
      item.coin = coin;
      gap = (!quiet_mode && $urandom_range(0, 2) == 0) ? pick_gap() + 1 : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, coin, key};
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(item);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write pool_size while idle, then clear so the new size takes effect.
   task automatic start_pool(input logic [10:0] size);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_POOL_SIZE, 2'b00};
      csr_pwdata  <= {21'b0, size};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.pool_size = size;
      send_request(ACT_CLEAR, 10'($urandom), 1'($urandom));
   endtask

   initial begin
      logic [10:0] size;
      int unsigned eff, n_items, hot, r, k, phases;
      logic [9:0] key;
      sb = new();
      phases = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(ACT_READ, 10'd0, 1'b0);
      send_request(ACT_DRAW, 10'd0, 1'b0);
      send_request(ACT_DRAW, 10'd0, 1'b0);
      send_request(ACT_DRAW, 10'd1023, 1'b1);
      send_request(ACT_DRAW, 10'd1023, 1'b1);
      send_request(ACT_DRAW, 10'd500, 1'b0);
      send_request(ACT_DRAW, 10'd500, 1'b0);
      send_request(ACT_DRAW, 10'd700, 1'b1);
      send_request(ACT_DRAW, 10'd700, 1'b1);
      send_request(ACT_READ, 10'd1023, 1'b1);
      send_request(ACT_READ, 10'd0, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b1);
      send_request(ACT_DRAW, 10'd450, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      send_request(ACT_SPARE, 10'd1023, 1'b1);
      start_pool(11'd2);
      send_request(ACT_DRAW, 10'd5, 1'b0);
      send_request(ACT_DRAW, 10'd1, 1'b0);
      send_request(ACT_DRAW, 10'd1, 1'b1);
      send_request(ACT_DRAW, 10'd0, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      start_pool(11'd0);
      send_request(ACT_DRAW, 10'd0, 1'b0);
      send_request(ACT_DRAW, 10'd1, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      start_pool(11'd2047);
      send_request(ACT_DRAW, 10'd1023, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      send_request(ACT_READ, 10'd0, 1'b0);
      phases = 4;

      while (requests_sent < TARGET_REQUESTS) begin
         r = $urandom_range(0, 99);
         if (r < 6) size = 11'd1024;
         else if (r < 12) size = 11'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1025, 2047));
         else if (r < 40) size = 11'($urandom_range(1, 16));
         else if (r < 88) size = 11'($urandom_range(17, 96));
         else size = 11'($urandom_range(97, 1023));
         eff = (size == 0) ? 1 : (size > MAX_POOL) ? MAX_POOL : size;
         n_items = (eff < 40) ? eff + eff / 2 + 6 : $urandom_range(40, 80);
         hot = $urandom_range(0, eff - 1);
         quiet_mode = ($urandom_range(0, 3) == 0);
         start_pool(size);
         phases++;
         for (k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < ((k < n_items / 2) ? 80 : 35)) begin
               if ($urandom_range(0, 9) == 0) key = 10'($urandom_range(0, 1023));
               else if (eff > 64 && $urandom_range(0, 1) == 0)
                  key = 10'((hot + $urandom_range(0, 31)) % eff);
               else key = 10'($urandom_range(0, eff - 1));
               send_request(ACT_DRAW, key, 1'($urandom));
            end else if (r < 94) begin
               send_request(ACT_READ, 10'($urandom), 1'($urandom));
            end else if (r < 97) begin
               send_request(ACT_SPARE, 10'($urandom), 1'($urandom));
            end else begin
               send_request(ACT_CLEAR, 10'($urandom), 1'($urandom));
            end
         end
      end

      wait_idle();
      repeat (70) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
      $display("Sent %0d requests over %0d pool settings, %0d results checked.",
               requests_sent, phases, sb.checked);
      $display("Covered %0d empty-pool draws, %0d out-of-range keys, %0d reads past the end.",
               sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_RANGE],
               sb.status_seen[STAT_NONE]);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d results outstanding.", sb.pending());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
